/* rtl/slpg_pkg.sv */
// shared types, constants and the 5x7 glyph table of the scrolling letter generator
// no dependencies; imported by every module of the block
`timescale 1ns / 1ps

package slpg_pkg;

  localparam int unsigned TIME_W       = 16;
  localparam int unsigned COORD_W      = 3;
  localparam int unsigned CHAN_W       = 8;
  localparam int unsigned LETTER_W     = 5;
  localparam int unsigned HUE_W        = 8;
  localparam int unsigned RECIP_SHIFT  = 24;

  localparam int unsigned GLYPH_COLS   = 5;
  localparam int unsigned GLYPH_ROWS   = 7;
  localparam int unsigned GLYPH_GAP    = 1;
  localparam int unsigned LETTER_COUNT = 26;
  localparam logic [LETTER_W-1:0] LAST_LETTER = 5'd25;
  localparam logic [HUE_W-1:0] HUE_LETTER_STEP = 8'd9;
  localparam logic [HUE_W-1:0] HUE_SECTOR = 8'd43;

  localparam logic [CHAN_W-1:0] SAT_RESET = 8'd160;
  localparam logic [CHAN_W-1:0] VAL_RESET = 8'd180;

  // configuration register indexes
  localparam logic [0:0] REG_SATURATION = 1'b0;
  localparam logic [0:0] REG_BRIGHTNESS = 1'b1;

  typedef enum logic [2:0] {
    SEC_RED     = 3'd0,
    SEC_YELLOW  = 3'd1,
    SEC_GREEN   = 3'd2,
    SEC_CYAN    = 3'd3,
    SEC_BLUE    = 3'd4,
    SEC_MAGENTA = 3'd5
  } hue_sector_e;

  typedef struct packed {
    logic [COORD_W-1:0] py;
    logic [COORD_W-1:0] px;
  } pixel_t;

  // red in the lowest byte
  typedef struct packed {
    logic [CHAN_W-1:0] blue;
    logic [CHAN_W-1:0] green;
    logic [CHAN_W-1:0] red;
  } rgb_t;

  // columns of each letter, bit 0 is the top row
  localparam logic [6:0] FONT_ROM [LETTER_COUNT][GLYPH_COLS] = '{
    '{7'h7e, 7'h09, 7'h09, 7'h09, 7'h7e}, '{7'h7f, 7'h49, 7'h49, 7'h49, 7'h36},
    '{7'h3e, 7'h41, 7'h41, 7'h41, 7'h22}, '{7'h7f, 7'h41, 7'h41, 7'h22, 7'h1c},
    '{7'h7f, 7'h49, 7'h49, 7'h49, 7'h41}, '{7'h7f, 7'h09, 7'h09, 7'h09, 7'h01},
    '{7'h3e, 7'h41, 7'h49, 7'h49, 7'h7a}, '{7'h7f, 7'h08, 7'h08, 7'h08, 7'h7f},
    '{7'h41, 7'h41, 7'h7f, 7'h41, 7'h41}, '{7'h20, 7'h40, 7'h41, 7'h3f, 7'h01},
    '{7'h7f, 7'h08, 7'h14, 7'h22, 7'h41}, '{7'h7f, 7'h40, 7'h40, 7'h40, 7'h40},
    '{7'h7f, 7'h02, 7'h0c, 7'h02, 7'h7f}, '{7'h7f, 7'h04, 7'h08, 7'h10, 7'h7f},
    '{7'h3e, 7'h41, 7'h41, 7'h41, 7'h3e}, '{7'h7f, 7'h09, 7'h09, 7'h09, 7'h06},
    '{7'h3e, 7'h41, 7'h51, 7'h21, 7'h5e}, '{7'h7f, 7'h09, 7'h19, 7'h29, 7'h46},
    '{7'h46, 7'h49, 7'h49, 7'h49, 7'h31}, '{7'h01, 7'h01, 7'h7f, 7'h01, 7'h01},
    '{7'h3f, 7'h40, 7'h40, 7'h40, 7'h3f}, '{7'h1f, 7'h20, 7'h40, 7'h20, 7'h1f},
    '{7'h7f, 7'h20, 7'h18, 7'h20, 7'h7f}, '{7'h63, 7'h14, 7'h08, 7'h14, 7'h63},
    '{7'h03, 7'h04, 7'h78, 7'h04, 7'h03}, '{7'h61, 7'h51, 7'h49, 7'h45, 7'h43}
  };

  function automatic logic [6:0] glyph_column(logic [LETTER_W-1:0] letter,
                                              logic [2:0] col);
    logic [6:0] bits;
    bits = '0;
    if (col < 3'(GLYPH_COLS) && letter < 5'(LETTER_COUNT)) begin
      bits = FONT_ROM[letter][col];
    end
    return bits;
  endfunction

endpackage

/* rtl/scrolling_letter_pixel_generator.sv */
// top level of the scrolling A-to-Z letter pixel generator
// depends on slpg_pkg, slpg_divc and slpg_hsv
`timescale 1ns / 1ps

// Usage:
//   s_axis carries one pixel request per transaction: scene time in ms and the
//   pixel column and row. m_axis returns one transaction per request with the
//   pixel color, in request order. Lit pixels of the scrolling letter take an
//   hsv color from the saturation and brightness registers; all others are black.
//   Registers are written through cfg_we_i / cfg_addr_i / cfg_wdata_i; the user
//   must write them only while no request is in flight; the block does not enforce this.
// Throughput: one pixel per cycle while m_axis_tready is high; the eleven-stage
//   pipeline (two three-stage constant dividers, letter clamp, glyph lookup,
//   three-stage color unit) holds one item per stage.
// Stall: each stage only holds while the stage after it is full and stalled, so
//   bubbles close up and s_axis_tready stays high until all 11 stages are full.
// Reset: empties the pipeline and loads saturation 160 and brightness 180.
module scrolling_letter_pixel_generator #(
  parameter int unsigned MATRIX_WIDTH   = 8,
  parameter int unsigned MATRIX_HEIGHT  = 8,
  parameter int unsigned SCROLL_STEP_MS = 90
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [23:0] s_axis_tdata,   // scene_time_ms[15:0], pixel_x[18:16], pixel_y[21:19]
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [23:0] m_axis_tdata,   // red[7:0], green[15:8], blue[23:16]
  input  logic        cfg_we_i,
  input  logic [0:0]  cfg_addr_i,
  input  logic [7:0]  cfg_wdata_i
);
  import slpg_pkg::*;

  localparam int unsigned NSTG   = 11;
  localparam int unsigned PERIOD = MATRIX_WIDTH + GLYPH_COLS + GLYPH_GAP;
  localparam int unsigned STEP_REM_W = (SCROLL_STEP_MS > 1) ? $clog2(SCROLL_STEP_MS) : 1;
  localparam int unsigned SH_W   = $clog2(PERIOD);
  localparam logic [SH_W-1:0] SHIFT_LAST = SH_W'(PERIOD - 1);
  localparam logic [7:0] WIDTH_8  = 8'(MATRIX_WIDTH);
  localparam logic [7:0] HEIGHT_8 = 8'(MATRIX_HEIGHT);
  localparam logic [7:0] GLYPH_END_8 = 8'(MATRIX_WIDTH + GLYPH_COLS);

  logic [CHAN_W-1:0] sat_q, val_q;
  logic [NSTG:1]     vld_q;
  logic [NSTG+1:1]   en;

  pixel_t                pix_q [1:7];
  logic [6:0]            steplo_q [4:6];
  logic [TIME_W-1:0]     step_w, letter_w;
  logic [STEP_REM_W-1:0] step_rem_w;
  logic [SH_W-1:0]       shift_w;

  logic [LETTER_W-1:0]   letter7_q;
  logic [SH_W-1:0]       shift7_q;
  logic [6:0]            step7_q;

  logic [7:0]            colsum;
  logic [7:0]            colidx;
  logic                  in_glyph, in_matrix;
  logic [7:0]            glyph8;
  logic                  lit8_d, lit8_q;
  logic [HUE_W-1:0]      hue8_d, hue8_q;
  rgb_t                  rgb;

  // configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sat_q <= SAT_RESET;
      val_q <= VAL_RESET;
    end else if (cfg_we_i) begin
      case (cfg_addr_i)
        REG_SATURATION: sat_q <= cfg_wdata_i;
        REG_BRIGHTNESS: val_q <= cfg_wdata_i;
        default: ;
      endcase
    end
  end

  // a stage loads when it is empty or its content moves on
  always_comb begin
    en[NSTG+1] = m_axis_tready;
    for (int k = NSTG; k >= 1; k--) begin
      en[k] = ~vld_q[k] | en[k+1];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else begin
      if (en[1]) vld_q[1] <= s_axis_tvalid;
      for (int k = 2; k <= NSTG; k++) begin
        if (en[k]) vld_q[k] <= vld_q[k-1];
      end
    end
  end

  // stages 1..3: step = time / SCROLL_STEP_MS
  slpg_divc #(
    .DIVISOR (SCROLL_STEP_MS),
    .REM_W   (STEP_REM_W)
  ) u_step_div (
    .clk_i (clk_i),
    .en_i  (en[3:1]),
    .num_i (s_axis_tdata[15:0]),
    .quo_o (step_w),
    .rem_o (step_rem_w)
  );

  // stages 4..6: letter and column shift = step / period
  slpg_divc #(
    .DIVISOR (PERIOD),
    .REM_W   (SH_W)
  ) u_letter_div (
    .clk_i (clk_i),
    .en_i  (en[6:4]),
    .num_i (step_w),
    .quo_o (letter_w),
    .rem_o (shift_w)
  );

  always_ff @(posedge clk_i) begin
    if (en[1]) pix_q[1] <= '{py: s_axis_tdata[21:19], px: s_axis_tdata[18:16]};
    for (int k = 2; k <= 7; k++) begin
      if (en[k]) pix_q[k] <= pix_q[k-1];
    end
    if (en[4]) steplo_q[4] <= step_w[6:0];
    if (en[5]) steplo_q[5] <= steplo_q[4];
    if (en[6]) steplo_q[6] <= steplo_q[5];

    // stage 7: hold the last frame past the final letter
    if (en[7]) begin
      step7_q <= steplo_q[6];
      if (letter_w >= TIME_W'(LETTER_COUNT)) begin
        letter7_q <= LAST_LETTER;
        shift7_q  <= SHIFT_LAST;
      end else begin
        letter7_q <= letter_w[LETTER_W-1:0];
        shift7_q  <= shift_w;
      end
    end

    if (en[8]) begin
      lit8_q <= lit8_d;
      hue8_q <= hue8_d;
    end
  end

  // stage 8: glyph column = px + shift - width
  always_comb begin
    colsum    = 8'(pix_q[7].px) + 8'(shift7_q);
    colidx    = colsum - WIDTH_8;
    in_glyph  = (colsum >= WIDTH_8) && (colsum < GLYPH_END_8);
    in_matrix = (8'(pix_q[7].px) < WIDTH_8) && (8'(pix_q[7].py) < HEIGHT_8);
    glyph8    = {1'b0, glyph_column(letter7_q, colidx[2:0])};
    lit8_d    = in_glyph & in_matrix & glyph8[pix_q[7].py];
    hue8_d    = 8'(letter7_q) * HUE_LETTER_STEP + {step7_q, 1'b0};
  end

  // stages 9..11: color, the last stage is the output register
  slpg_hsv u_hsv (
    .clk_i (clk_i),
    .en_i  (en[11:9]),
    .lit_i (lit8_q),
    .hue_i (hue8_q),
    .sat_i (sat_q),
    .val_i (val_q),
    .rgb_o (rgb)
  );

  assign s_axis_tready = en[1];
  assign m_axis_tvalid = vld_q[NSTG];
  assign m_axis_tdata  = rgb;

`ifndef SYNTHESIS
  a_step_rem: assert property (@(posedge clk_i) disable iff (!rst_ni)
    vld_q[3] |-> (32'(step_rem_w) < SCROLL_STEP_MS))
    else $error("step remainder not below the scroll step");

  a_letter_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    vld_q[7] |-> (letter7_q <= LAST_LETTER))
    else $error("letter index beyond the last letter");

  a_shift_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    vld_q[7] |-> (32'(shift7_q) < PERIOD))
    else $error("column shift not below the letter period");

  a_empty_ready: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (vld_q == '0) |-> s_axis_tready)
    else $error("empty pipeline refuses a transaction");
`endif

endmodule

/* rtl/slpg_divc.sv */
// three-stage divider of a time-wide value by a constant (reciprocal multiply, one correction)
// depends on slpg_pkg
`timescale 1ns / 1ps

module slpg_divc #(
  parameter int unsigned DIVISOR = 90,
  parameter int unsigned REM_W   = 7
) (
  input  logic                       clk_i,
  input  logic [2:0]                 en_i,   // stage load enables, bit 0 first
  input  logic [slpg_pkg::TIME_W-1:0] num_i,
  output logic [slpg_pkg::TIME_W-1:0] quo_o,
  output logic [REM_W-1:0]           rem_o
);
  import slpg_pkg::*;

  localparam int unsigned RCP_W  = RECIP_SHIFT + 1;
  localparam int unsigned PROD_W = TIME_W + RCP_W;
  localparam int unsigned DIV_W  = $clog2(DIVISOR + 1);
  localparam logic [RCP_W-1:0] RECIP = RCP_W'((64'd1 << RECIP_SHIFT) / DIVISOR);
  localparam logic [DIV_W-1:0] DIV_C = DIV_W'(DIVISOR);
  localparam logic [TIME_W-1:0] DIV_N = TIME_W'(DIVISOR);

  logic [PROD_W-1:0]       prod_q;
  logic [TIME_W-1:0]       num1_q, num2_q;
  logic [TIME_W-1:0]       q0_d, q0_q, qd_q;
  logic [TIME_W+DIV_W-1:0] qd_full;
  logic [TIME_W-1:0]       diff;
  logic [TIME_W-1:0]       quo_q;
  logic [REM_W-1:0]        rem_q;

  // estimate is low by at most one since the numerator is far below 2^RECIP_SHIFT
  assign q0_d    = prod_q[RECIP_SHIFT +: TIME_W];
  assign qd_full = {{DIV_W{1'b0}}, q0_d} * {{TIME_W{1'b0}}, DIV_C};
  assign diff    = num2_q - qd_q;

  always_ff @(posedge clk_i) begin
    if (en_i[0]) begin
      prod_q <= {{RCP_W{1'b0}}, num_i} * {{TIME_W{1'b0}}, RECIP};
      num1_q <= num_i;
    end
    if (en_i[1]) begin
      q0_q   <= q0_d;
      qd_q   <= qd_full[TIME_W-1:0];
      num2_q <= num1_q;
    end
    if (en_i[2]) begin
      if (diff >= DIV_N) begin
        quo_q <= q0_q + 1'b1;
        rem_q <= REM_W'(diff - DIV_N);
      end else begin
        quo_q <= q0_q;
        rem_q <= REM_W'(diff);
      end
    end
  end

  assign quo_o = quo_q;
  assign rem_o = rem_q;

endmodule

/* rtl/slpg_hsv.sv */
// three-stage integer hsv to rgb color converter, black when the pixel is unlit
// depends on slpg_pkg
`timescale 1ns / 1ps

module slpg_hsv (
  input  logic                       clk_i,
  input  logic [2:0]                 en_i,   // stage load enables, bit 0 first
  input  logic                       lit_i,
  input  logic [slpg_pkg::HUE_W-1:0]  hue_i,
  input  logic [slpg_pkg::CHAN_W-1:0] sat_i,
  input  logic [slpg_pkg::CHAN_W-1:0] val_i,
  output slpg_pkg::rgb_t             rgb_o
);
  import slpg_pkg::*;

  hue_sector_e       sector_d, sector_q, sector2_q;
  logic [HUE_W-1:0]  base, frac_d, frac_q;
  logic              lit_q, lit2_q;
  logic [15:0]       pm, sfm, sfnm, qm, tm;
  logic [CHAN_W-1:0] p_q, sf_q, sfn_q, q_c, t_c;
  rgb_t              rgb_d, rgb_q;

  // sector = hue / 43, by threshold compares
  always_comb begin
    if (hue_i >= 8'd215) begin
      sector_d = SEC_MAGENTA;
      base     = 8'd215;
    end else if (hue_i >= 8'd172) begin
      sector_d = SEC_BLUE;
      base     = 8'd172;
    end else if (hue_i >= 8'd129) begin
      sector_d = SEC_CYAN;
      base     = 8'd129;
    end else if (hue_i >= 8'd86) begin
      sector_d = SEC_GREEN;
      base     = 8'd86;
    end else if (hue_i >= HUE_SECTOR) begin
      sector_d = SEC_YELLOW;
      base     = HUE_SECTOR;
    end else begin
      sector_d = SEC_RED;
      base     = 8'd0;
    end
    frac_d = 8'((hue_i - base) * 8'd6);
  end

  assign pm   = {8'd0, val_i} * {8'd0, ~sat_i};
  assign sfm  = {8'd0, sat_i} * {8'd0, frac_q};
  assign sfnm = {8'd0, sat_i} * {8'd0, ~frac_q};
  assign qm   = {8'd0, val_i} * {8'd0, ~sf_q};
  assign tm   = {8'd0, val_i} * {8'd0, ~sfn_q};
  assign q_c  = qm[15:8];
  assign t_c  = tm[15:8];

  always_comb begin
    case (sector2_q)
      SEC_YELLOW:  rgb_d = '{blue: p_q,   green: val_i, red: q_c};
      SEC_GREEN:   rgb_d = '{blue: t_c,   green: val_i, red: p_q};
      SEC_CYAN:    rgb_d = '{blue: val_i, green: q_c,   red: p_q};
      SEC_BLUE:    rgb_d = '{blue: val_i, green: p_q,   red: t_c};
      SEC_MAGENTA: rgb_d = '{blue: q_c,   green: p_q,   red: val_i};
      default:     rgb_d = '{blue: p_q,   green: t_c,   red: val_i};
    endcase
    if (!lit2_q) begin
      rgb_d = '0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i[0]) begin
      sector_q <= sector_d;
      frac_q   <= frac_d;
      lit_q    <= lit_i;
    end
    if (en_i[1]) begin
      sector2_q <= sector_q;
      lit2_q    <= lit_q;
      p_q       <= pm[15:8];
      sf_q      <= sfm[15:8];
      sfn_q     <= sfnm[15:8];
    end
    if (en_i[2]) begin
      rgb_q <= rgb_d;
    end
  end

  assign rgb_o = rgb_q;

endmodule
